// ===== sv/vab_pkg.sv =====
// Package for the vector angle block: widths, CORDIC constants and shared types.
// Used by every module under sv/; depends on nothing.
package vab_pkg;

  localparam int unsigned ComponentBitsDef = 16;
  localparam int unsigned AngleFracBitsDef = 13;
  localparam int unsigned AccFrac          = 32;
  localparam int unsigned CordicSteps      = 32;
  localparam int unsigned TableLen         = 11;
  localparam int unsigned OpBits           = 36;
  localparam int unsigned AccBits          = 36;
  localparam int unsigned SqBits           = 64;
  localparam logic [AccBits-1:0] PiQ32     = 36'd13493037705;

  // Arctangent of two to the power minus i, Q0.32.
  function automatic logic [AccBits-1:0] atan_q32(input logic [5:0] idx);
    logic [AccBits-1:0] res;
    begin
      res = '0;
      case (idx)
        6'd0:    res = 36'd3373259426;
        6'd1:    res = 36'd1991351318;
        6'd2:    res = 36'd1052175346;
        6'd3:    res = 36'd534100635;
        6'd4:    res = 36'd268086748;
        6'd5:    res = 36'd134174063;
        6'd6:    res = 36'd67103403;
        6'd7:    res = 36'd33553749;
        6'd8:    res = 36'd16777131;
        6'd9:    res = 36'd8388597;
        6'd10:   res = 36'd4194303;
        default: res = AccBits'(64'd1 << (AccFrac - 32'(idx)));
      endcase
      return res;
    end
  endfunction

  // Sideband that travels alongside each vector pair through the pipeline.
  typedef struct packed {
    logic valid;
    logic zero;
    logic neg;
  } vab_side_t;

endpackage

// ===== sv/vab_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation, registered.
// Depends on vab_pkg.
module vab_cordic_cell #(
  parameter int unsigned Step = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  vab_pkg::vab_side_t            side_i,
  input  logic signed [vab_pkg::OpBits-1:0]  x_i,
  input  logic signed [vab_pkg::OpBits-1:0]  y_i,
  input  logic signed [vab_pkg::AccBits-1:0] z_i,
  output vab_pkg::vab_side_t            side_o,
  output logic signed [vab_pkg::OpBits-1:0]  x_o,
  output logic signed [vab_pkg::AccBits-1:0] z_o,
  output logic signed [vab_pkg::OpBits-1:0]  y_o
);
  import vab_pkg::*;

  logic signed [OpBits-1:0]  x_d, y_d, x_q, y_q, xs, ys;
  logic signed [AccBits-1:0] z_d, z_q, t;
  vab_side_t side_q;

  // Rotate towards the x axis, accumulating the angle.
  always_comb begin
    xs = x_i >>> Step;
    ys = y_i >>> Step;
    t  = signed'(atan_q32(6'(Step)));
    if (!y_i[OpBits-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + t;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign side_o = side_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
endmodule

// ===== sv/vab_sqrt_cell.sv =====
// One step of a restoring square root, two radicand bits per step, registered.
// Depends on vab_pkg.
module vab_sqrt_cell #(
  parameter int unsigned Step = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [vab_pkg::SqBits-1:0]   rem_i,
  input  logic [vab_pkg::SqBits/2-1:0] root_i,
  input  logic [vab_pkg::SqBits-1:0]   rad_i,
  input  logic [vab_pkg::OpBits-1:0]   x_i,
  input  vab_pkg::vab_side_t           side_i,
  output logic [vab_pkg::SqBits-1:0]   rem_o,
  output logic [vab_pkg::SqBits/2-1:0] root_o,
  output logic [vab_pkg::SqBits-1:0]   rad_o,
  output logic [vab_pkg::OpBits-1:0]   x_o,
  output vab_pkg::vab_side_t           side_o
);
  import vab_pkg::*;

  localparam int unsigned Hi = SqBits - 1 - 2 * Step;

  logic [SqBits-1:0]   rem_d, rem_q, rad_q, trial;
  logic [SqBits/2-1:0] root_d, root_q;
  logic [OpBits-1:0]   x_q;
  vab_side_t           side_q;
  logic [SqBits+1:0]   cur;

  // Bring in the next pair of radicand bits and try the new root bit.
  always_comb begin
    cur   = {rem_i, rad_i[Hi -: 2]};
    trial = {root_i, 2'b01};
    if (cur[SqBits-1:0] >= trial || cur[SqBits+1:SqBits] != 2'b00) begin
      rem_d  = cur[SqBits-1:0] - trial;
      root_d = {root_i[SqBits/2-2:0], 1'b1};
    end else begin
      rem_d  = cur[SqBits-1:0];
      root_d = {root_i[SqBits/2-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_i;
      x_q    <= x_i;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;
  assign x_o    = x_q;
  assign side_o = side_q;
endmodule

// ===== sv/vab_front.sv =====
// Front end: scales wide components, forms dot and cross products, normalises.
// Depends on vab_pkg. Pipelined in five registered stages.
module vab_front #(
  parameter int unsigned ComponentBits = vab_pkg::ComponentBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [ComponentBits-1:0]   u_x_i,
  input  logic [ComponentBits-1:0]   u_y_i,
  input  logic [ComponentBits-1:0]   u_z_i,
  input  logic [ComponentBits-1:0]   v_x_i,
  input  logic [ComponentBits-1:0]   v_y_i,
  input  logic [ComponentBits-1:0]   v_z_i,
  output vab_pkg::vab_side_t         side_o,
  output logic [vab_pkg::OpBits-1:0] x_o,
  output logic [vab_pkg::SqBits-1:0] rad_o
);
  import vab_pkg::*;

  localparam int unsigned CB = ComponentBits;

  // Shift needed so that a vector fits sixteen bits.
  function automatic logic [5:0] fit_shift(input logic signed [CB-1:0] a,
                                           input logic signed [CB-1:0] b,
                                           input logic signed [CB-1:0] c);
    logic [5:0] s;
    logic signed [CB-1:0] ta, tb, tc;
    begin
      s = '0;
      for (int k = 0; k <= 32; k++) begin
        ta = a >>> k;
        tb = b >>> k;
        tc = c >>> k;
        if (s == 6'd0 && k <= CB && ta >= -32768 && ta <= 32767 && tb >= -32768
            && tb <= 32767 && tc >= -32768 && tc <= 32767 && k > 0) begin
          s = 6'(k);
        end
      end
      if (a >= -32768 && a <= 32767 && b >= -32768 && b <= 32767 && c >= -32768
          && c <= 32767) begin
        s = 6'd0;
      end
      return s;
    end
  endfunction

  // Stage 1: zero detection and scaling to sixteen bits.
  logic signed [CB-1:0] ua, ub, uc, va, vb, vc;
  logic [5:0] su, sv;
  logic signed [15:0] u0_q, u1_q, u2_q, v0_q, v1_q, v2_q;
  vab_side_t s1_q, s2_q, s3_q, s4_q, s5_q;

  always_comb begin
    ua = signed'(u_x_i); ub = signed'(u_y_i); uc = signed'(u_z_i);
    va = signed'(v_x_i); vb = signed'(v_y_i); vc = signed'(v_z_i);
    su = fit_shift(ua, ub, uc);
    sv = fit_shift(va, vb, vc);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u0_q <= 16'(ua >>> su); u1_q <= 16'(ub >>> su); u2_q <= 16'(uc >>> su);
      v0_q <= 16'(va >>> sv); v1_q <= 16'(vb >>> sv); v2_q <= 16'(vc >>> sv);
    end
  end

  // Stage 2: the nine products.
  logic signed [31:0] p00, p11, p22, p12, p21, p20, p02, p01, p10;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00 <= u0_q * v0_q; p11 <= u1_q * v1_q; p22 <= u2_q * v2_q;
      p12 <= u1_q * v2_q; p21 <= u2_q * v1_q; p20 <= u2_q * v0_q;
      p02 <= u0_q * v2_q; p01 <= u0_q * v1_q; p10 <= u1_q * v0_q;
    end
  end

  // Stage 3: dot product and cross components.
  logic signed [33:0] dot_q, c0_q, c1_q, c2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q <= 34'(p00) + 34'(p11) + 34'(p22);
      c0_q  <= 34'(p12) - 34'(p21);
      c1_q  <= 34'(p20) - 34'(p02);
      c2_q  <= 34'(p01) - 34'(p10);
    end
  end

  // Stage 4: squares of the cross components and dot magnitude.
  logic [32:0] a0, a1, a2;
  logic [63:0] q0_q, q1_q, q2_q;
  logic [33:0] xm4_q;
  always_comb begin
    a0 = c0_q[33] ? 33'(-c0_q) : 33'(c0_q);
    a1 = c1_q[33] ? 33'(-c1_q) : 33'(c1_q);
    a2 = c2_q[33] ? 33'(-c2_q) : 33'(c2_q);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q0_q  <= 64'(a0) * 64'(a0);
      q1_q  <= 64'(a1) * 64'(a1);
      q2_q  <= 64'(a2) * 64'(a2);
      xm4_q <= dot_q[33] ? 34'(-dot_q) : 34'(dot_q);
    end
  end

  // Stage 5: cross magnitude squared, then scaling by a power of four.
  logic [63:0] c2sum, ym_est, rad;
  logic [63:0] xm;
  logic [4:0]  j;
  logic        big;
  logic [63:0] m;
  always_comb begin
    c2sum = q0_q + q1_q + q2_q;
    xm    = 64'(xm4_q);
    // Root estimate only decides the shift: floor sqrt >= 2^31 iff c2 >= 2^62.
    big   = (xm >= 64'd2147483648) || (c2sum >= 64'h4000_0000_0000_0000);
    ym_est = '0;
    for (int k = 0; k < 32; k++) begin
      if (c2sum >= (64'd1 << (2 * k))) begin
        ym_est = 64'd1 << k;
      end
    end
    m = (xm > ym_est) ? xm : ym_est;
    j = '0;
    for (int k = 1; k <= 30; k++) begin
      if (m != 0 && (m << k) < 64'd2147483648 && j == 5'(k - 1)) begin
        j = 5'(k);
      end
    end
    rad = big ? c2sum : (c2sum << (2 * j));
  end

  logic [OpBits-1:0] x_q;
  logic [SqBits-1:0] rad_q;
  logic              half_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= big ? OpBits'(xm >> 1) : OpBits'(xm << j);
      rad_q <= rad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0; s2_q <= '0; s3_q <= '0; s4_q <= '0; s5_q <= '0; half_q <= 1'b0;
    end else if (en_i) begin
      s1_q.valid <= valid_i;
      s1_q.zero  <= (ua == 0 && ub == 0 && uc == 0) || (va == 0 && vb == 0 && vc == 0);
      s1_q.neg   <= 1'b0;
      s2_q <= s1_q;
      s3_q <= '{valid: s2_q.valid, zero: s2_q.zero, neg: 1'b0};
      s4_q <= '{valid: s3_q.valid, zero: s3_q.zero, neg: dot_q[33]};
      s5_q <= s4_q;
      half_q <= big;
    end
  end

  assign side_o = s5_q;
  assign x_o    = x_q;
  // A halved cross root is the root of a quarter of the radicand, floored twice.
  assign rad_o  = half_q ? {1'b1, rad_q[SqBits-2:0]} : {1'b0, rad_q[SqBits-2:0]};
endmodule

// ===== sv/vector_angle_between.sv =====
// Top level of the vector angle block: front end, square-root cells, CORDIC cells.
// Depends on vab_pkg, vab_front, vab_sqrt_cell and vab_cordic_cell.
//
//  channel | direction | fields                               | handshake
//  --------+-----------+--------------------------------------+------------------
//  input   | in        | first_x/y/z, second_x/y/z            | in_valid_i/ready_o
//  output  | out       | angle, zero_length                   | out_valid_o/ready_i
//
// One transaction is taken every cycle while the output is not held; the path runs
// through the front end, the square-root and CORDIC cell rows and the output register.
// Reset clears all valid bits; payload registers are left as they are.
// When the output is held, the whole pipeline stalls together; ready goes low
// only while the output register holds a result that has not been taken.
module vector_angle_between #(
  parameter int unsigned COMPONENT_BITS      = vab_pkg::ComponentBitsDef,
  parameter int unsigned ANGLE_FRACTION_BITS = vab_pkg::AngleFracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COMPONENT_BITS-1:0]  first_x_i,
  input  logic signed [COMPONENT_BITS-1:0]  first_y_i,
  input  logic signed [COMPONENT_BITS-1:0]  first_z_i,
  input  logic signed [COMPONENT_BITS-1:0]  second_x_i,
  input  logic signed [COMPONENT_BITS-1:0]  second_y_i,
  input  logic signed [COMPONENT_BITS-1:0]  second_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ANGLE_FRACTION_BITS+1:0]    angle_o,
  output logic                              zero_length_o
);
  import vab_pkg::*;

  localparam int unsigned AngleBits = ANGLE_FRACTION_BITS + 2;
  localparam int unsigned Drop      = AccFrac - ANGLE_FRACTION_BITS;
  localparam int unsigned SqSteps   = SqBits / 2;

  logic en;
  logic out_valid_q;
  logic [AngleBits-1:0] angle_q;
  logic zero_q;

  // The pipeline advances unless a finished result is being held.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  vab_side_t         fs;
  logic [OpBits-1:0] fx;
  logic [SqBits-1:0] frad;

  vab_front #(.ComponentBits(COMPONENT_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i && en),
    .u_x_i(first_x_i), .u_y_i(first_y_i), .u_z_i(first_z_i),
    .v_x_i(second_x_i), .v_y_i(second_y_i), .v_z_i(second_z_i),
    .side_o(fs), .x_o(fx), .rad_o(frad)
  );

  // Square-root row; the top radicand bit marks a halved operand.
  logic [SqBits-1:0]   rem  [SqSteps+1];
  logic [SqSteps-1:0]  root [SqSteps+1];
  logic [SqBits-1:0]   rad  [SqSteps+1];
  logic [OpBits-1:0]   sx   [SqSteps+1];
  vab_side_t           ss   [SqSteps+1];
  logic                half [SqSteps+1];

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = {1'b0, frad[SqBits-2:0]};
  assign sx[0]   = fx;
  assign ss[0]   = fs;
  assign half[0] = frad[SqBits-1];

  for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt
    vab_sqrt_cell #(.Step(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .rem_i(rem[g]), .root_i(root[g]), .rad_i(rad[g]), .x_i(sx[g]), .side_i(ss[g]),
      .rem_o(rem[g+1]), .root_o(root[g+1]), .rad_o(rad[g+1]), .x_o(sx[g+1]),
      .side_o(ss[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        half[g+1] <= half[g];
      end
    end
  end

  // CORDIC row.
  logic signed [OpBits-1:0]  cx [CordicSteps+1];
  logic signed [OpBits-1:0]  cy [CordicSteps+1];
  logic signed [AccBits-1:0] cz [CordicSteps+1];
  vab_side_t                 cs [CordicSteps+1];

  assign cx[0] = signed'(sx[SqSteps]);
  assign cy[0] = half[SqSteps] ? signed'(OpBits'(root[SqSteps] >> 1))
                               : signed'(OpBits'(root[SqSteps]));
  assign cz[0] = '0;
  assign cs[0] = ss[SqSteps];

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
    vab_cordic_cell #(.Step(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .side_i(cs[g]),
      .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]),
      .side_o(cs[g+1]), .x_o(cx[g+1]), .z_o(cz[g+1]), .y_o(cy[g+1])
    );
  end

  // Clamp, fold obtuse angles and round to the output precision.
  logic signed [AccBits-1:0] zc;
  logic [AccBits-1:0]        zf, zr;
  always_comb begin
    zc = cz[CordicSteps];
    if (zc < 0) begin
      zc = '0;
    end
    if (zc > signed'(PiQ32)) begin
      zc = signed'(PiQ32);
    end
    zf = cs[CordicSteps].neg ? (PiQ32 - AccBits'(zc)) : AccBits'(zc);
    zr = (zf + (AccBits'(1) << (Drop - 1))) >> Drop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cs[CordicSteps].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q  <= cs[CordicSteps].zero;
      angle_q <= cs[CordicSteps].zero ? '0 : AngleBits'(zr);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign angle_o       = angle_q;
  assign zero_length_o = zero_q;

  // A held result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(angle_o))
    else $error("held result changed");
  // A zero-length result always reports angle zero.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |-> angle_o == '0)
    else $error("zero length with nonzero angle");
  // The angle never exceeds pi.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(angle_o) <= ((32'd1 << ANGLE_FRACTION_BITS) * 32'd3217 + 32'd512) / 32'd1024)
    else $error("angle out of range");
  // Ready is low only when a result waits.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("stall without pending result");
endmodule
